@@ rtl/carm_pkg.sv @@
// ============================================================================
// carm_pkg: shared types, constants and functions
// Widths, register indexes and pixel scaling used by the clipped alpha
// rectangle multiply unit.
// ============================================================================
package carm_pkg;

    // Largest layer dimension; layer sizes saturate at this value.
    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);

    // Field widths.
    localparam int PIX_W     = 12;  // pixel position
    localparam int HALF_W    = 16;  // one half of a packed register
    localparam int DATA_W    = 32;  // widest configuration register
    localparam int BYTE_W    = 8;
    localparam int CLEAR_W   = 9;
    localparam int CFG_IDX_W = 3;

    // Signed working width of the clip arithmetic: holds offset sums of
    // two 16-bit values plus a 16-bit size with sign.
    localparam int COORD_W = 20;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEST_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ADDITIVE_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_VALUE   = 3'd6;

    // Clear value after reset: clearing disabled.
    localparam logic [CLEAR_W-1:0] CLEAR_RESET = 9'd256;
    localparam int CLEAR_OFF_BIT = 8;

    localparam logic [BYTE_W-1:0] ALPHA_FULL = 8'hff;
    localparam logic [BYTE_W-1:0] ALPHA_NONE = 8'h00;

    typedef struct packed {
        logic [DATA_W-1:0]  dest_offset;
        logic [DATA_W-1:0]  source_offset;
        logic [DATA_W-1:0]  copy_size;
        logic [DATA_W-1:0]  source_size;
        logic [DATA_W-1:0]  dest_size;
        logic               additive_mode;
        logic [CLEAR_W-1:0] clear_value;
    } t_cfg;

    // Clipped copy rectangle and clip window, in signed coordinates.
    typedef struct packed {
        logic                      active;  // copy size non-zero
        logic                      empty;   // nothing left after clipping
        logic signed [COORD_W-1:0] win_w;
        logic signed [COORD_W-1:0] win_h;
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] y_hi;
    } t_rect;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [DATA_W-1:0] dest_pixel;
        logic [BYTE_W-1:0] source_alpha;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] result_pixel;
        logic              changed;
    } t_out_item;

    // Saturate a 16-bit size at MAX_DIMENSION.
    function automatic logic [DIM_W-1:0] dim_sat(input logic [HALF_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v > HALF_W'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // byte * alpha / 255, rounded as (m + (m >> 7)) >> 8.
    function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] a);
        logic [2*BYTE_W-1:0] m;
        logic [2*BYTE_W:0]   s;
        m = b * a;
        s = {1'b0, m} + {1'b0, (m >> 7)};
        return s[2*BYTE_W-1:BYTE_W];
    endfunction

    function automatic logic [DATA_W-1:0] scale_pixel(input logic [DATA_W-1:0] p,
                                                      input logic [BYTE_W-1:0] a);
        logic [DATA_W-1:0] r;
        if (a == ALPHA_FULL) begin
            r = p;
        end else if (a == ALPHA_NONE) begin
            r = '0;
        end else begin
            r = {scale_byte(p[31:24], a), scale_byte(p[23:16], a),
                 scale_byte(p[15:8], a), scale_byte(p[7:0], a)};
        end
        return r;
    endfunction

endpackage

@@ rtl/carm_in_if.sv @@
// ============================================================================
// carm_in_if: input item channel
// Valid/ready channel carrying one destination pixel and its source alpha.
// ============================================================================
interface carm_in_if;
    logic                           valid;
    logic                           ready;
    logic [carm_pkg::PIX_W-1:0]     pixel_x;
    logic [carm_pkg::PIX_W-1:0]     pixel_y;
    logic [carm_pkg::DATA_W-1:0]    dest_pixel;
    logic [carm_pkg::BYTE_W-1:0]    source_alpha;

    modport source (output valid, output pixel_x, output pixel_y,
                    output dest_pixel, output source_alpha, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input dest_pixel, input source_alpha, output ready);
endinterface

@@ rtl/carm_out_if.sv @@
// ============================================================================
// carm_out_if: result item channel
// Valid/ready channel carrying the new pixel value and its write flag.
// ============================================================================
interface carm_out_if;
    logic                           valid;
    logic                           ready;
    logic [carm_pkg::DATA_W-1:0]    result_pixel;
    logic                           changed;

    modport source (output valid, output result_pixel, output changed, input ready);
    modport sink   (input valid, input result_pixel, input changed, output ready);
endinterface

@@ rtl/carm_clip.sv @@
// ============================================================================
// carm_clip: copy rectangle clipping
// Clips the copy rectangle against the source layer and then the clip
// window, and registers the result for the pixel datapath.
// ============================================================================
module carm_clip (
    input  logic             i_clk,
    input  carm_pkg::t_cfg   i_cfg,
    output carm_pkg::t_rect  o_rect
);

    localparam int CW  = carm_pkg::COORD_W;
    localparam int HW  = carm_pkg::HALF_W;
    localparam int DW  = carm_pkg::DIM_W;

    logic signed [CW-1:0] sx, sy, w, h, sw, sh, dw, dh, dx, dy;
    logic signed [CW-1:0] sx1, sy1, w1, h1, dx1, dy1, w2, h2;
    logic signed [CW-1:0] dx2, dy2, w3, h3, w4, h4;
    logic                 e1, e2, e3;
    carm_pkg::t_rect      n_rect;
    carm_pkg::t_rect      r_rect;

    always_comb begin
        sx = $signed({{(CW-HW){i_cfg.source_offset[15]}}, i_cfg.source_offset[15:0]});
        sy = $signed({{(CW-HW){i_cfg.source_offset[31]}}, i_cfg.source_offset[31:16]});
        dx = $signed({{(CW-HW){i_cfg.dest_offset[15]}}, i_cfg.dest_offset[15:0]});
        dy = $signed({{(CW-HW){i_cfg.dest_offset[31]}}, i_cfg.dest_offset[31:16]});
        w  = $signed({{(CW-HW){1'b0}}, i_cfg.copy_size[15:0]});
        h  = $signed({{(CW-HW){1'b0}}, i_cfg.copy_size[31:16]});
        sw = $signed({{(CW-DW){1'b0}}, carm_pkg::dim_sat(i_cfg.source_size[15:0])});
        sh = $signed({{(CW-DW){1'b0}}, carm_pkg::dim_sat(i_cfg.source_size[31:16])});
        dw = $signed({{(CW-DW){1'b0}}, carm_pkg::dim_sat(i_cfg.dest_size[15:0])});
        dh = $signed({{(CW-DW){1'b0}}, carm_pkg::dim_sat(i_cfg.dest_size[31:16])});

        // Against the source layer.
        e1 = (sx + w <= 0) || (sy + h <= 0) || (sx >= sw) || (sy >= sh);
        if (sx < 0) begin
            w1  = w + sx;
            dx1 = dx - sx;
            sx1 = '0;
        end else begin
            w1  = w;
            dx1 = dx;
            sx1 = sx;
        end
        if (sy < 0) begin
            h1  = h + sy;
            dy1 = dy - sy;
            sy1 = '0;
        end else begin
            h1  = h;
            dy1 = dy;
            sy1 = sy;
        end
        w2 = (sx1 + w1 > sw) ? sw - sx1 : w1;
        h2 = (sy1 + h1 > sh) ? sh - sy1 : h1;

        // Against the clip window.
        e2 = (dx1 + w2 <= 0) || (dy1 + h2 <= 0) || (dx1 >= dw) || (dy1 >= dh);
        if (dx1 < 0) begin
            w3  = w2 + dx1;
            dx2 = '0;
        end else begin
            w3  = w2;
            dx2 = dx1;
        end
        if (dy1 < 0) begin
            h3  = h2 + dy1;
            dy2 = '0;
        end else begin
            h3  = h2;
            dy2 = dy1;
        end
        w4 = (dx2 + w3 > dw) ? dw - dx2 : w3;
        h4 = (dy2 + h3 > dh) ? dh - dy2 : h3;
        e3 = (w4 <= 0) || (h4 <= 0);

        n_rect.active = (i_cfg.copy_size[15:0] != '0) && (i_cfg.copy_size[31:16] != '0);
        n_rect.empty  = e1 || e2 || e3;
        n_rect.win_w  = dw;
        n_rect.win_h  = dh;
        n_rect.x_lo   = dx2;
        n_rect.x_hi   = dx2 + w4;
        n_rect.y_lo   = dy2;
        n_rect.y_hi   = dy2 + h4;
    end

    // Follow the configuration; the clipped result is registered.
    always_ff @(posedge i_clk) begin
        r_rect <= n_rect;
    end

    assign o_rect = r_rect;

endmodule

@@ rtl/clipped_alpha_rect_multiply_unit.sv @@
// ============================================================================
// clipped_alpha_rect_multiply_unit: alpha mask multiply with rect clipping
// Scales destination pixels by a source alpha inside a clipped copy
// rectangle and optionally clears the rest of the clip window.
// ============================================================================
//
//  channel   direction  handshake        payload
//  i_in      sink       valid / ready    pixel_x, pixel_y, dest_pixel,
//                                        source_alpha
//  o_out     source     valid / ready    result_pixel, changed
//  i_cfg_*   write      i_cfg_we         i_cfg_index, i_cfg_data
//
//  One item per clock sustained while o_out.ready stays high; an accepted
//  item passes through the input register, then the result register,
//  before it shows on o_out.
//  The clipped rectangle is registered from the configuration and is ready
//  once a write has passed the configuration register and clip register.
//  i_rst_n is synchronous, active low: clears both valid flags and resets
//  the configuration registers.
//  A stalled result holds in the output register; the input register takes
//  an item while it is empty or the output register is free or draining.
//
module clipped_alpha_rect_multiply_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [carm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [carm_pkg::DATA_W-1:0]        i_cfg_data,
    carm_in_if.sink                            i_in,
    carm_out_if.source                         o_out
);

    localparam int CW = carm_pkg::COORD_W;
    localparam int PW = carm_pkg::PIX_W;

    carm_pkg::t_cfg      r_cfg;
    carm_pkg::t_rect     rect;
    carm_pkg::t_in_item  r_s1;
    carm_pkg::t_out_item r_out;
    carm_pkg::t_out_item n_out;
    logic                r_s1_v;
    logic                r_out_v;
    logic                load_out;
    logic                s1_free;
    logic                accept;

    logic signed [CW-1:0]              px_s, py_s;
    logic                              in_win, in_rect, clearing;
    logic [carm_pkg::BYTE_W-1:0]       alpha_sel;
    logic [carm_pkg::DATA_W-1:0]       scaled;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_offset   <= '0;
            r_cfg.source_offset <= '0;
            r_cfg.copy_size     <= '0;
            r_cfg.source_size   <= '0;
            r_cfg.dest_size     <= '0;
            r_cfg.additive_mode <= 1'b0;
            r_cfg.clear_value   <= carm_pkg::CLEAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                carm_pkg::REG_DEST_OFFSET:   r_cfg.dest_offset   <= i_cfg_data;
                carm_pkg::REG_SOURCE_OFFSET: r_cfg.source_offset <= i_cfg_data;
                carm_pkg::REG_COPY_SIZE:     r_cfg.copy_size     <= i_cfg_data;
                carm_pkg::REG_SOURCE_SIZE:   r_cfg.source_size   <= i_cfg_data;
                carm_pkg::REG_DEST_SIZE:     r_cfg.dest_size     <= i_cfg_data;
                carm_pkg::REG_ADDITIVE_MODE: r_cfg.additive_mode <= i_cfg_data[0];
                carm_pkg::REG_CLEAR_VALUE: begin
                    r_cfg.clear_value <= i_cfg_data[carm_pkg::CLEAR_W-1:0];
                end
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Clipped rectangle, registered off the configuration.
    carm_clip u_clip (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .o_rect (rect)
    );

    // ------------------------------------------------------------------
    // Handshake: advance the input register whenever the result register
    // is empty or being taken this cycle.
    // ------------------------------------------------------------------
    assign load_out   = r_s1_v && (!r_out_v || o_out.ready);
    assign s1_free    = !r_s1_v || load_out;
    assign accept     = i_in.valid && s1_free;
    assign i_in.ready = s1_free;

    // ------------------------------------------------------------------
    // Pixel datapath: window test, rectangle test, one set of byte
    // multipliers shared by the copy and clear paths.
    // ------------------------------------------------------------------
    always_comb begin
        px_s = $signed({{(CW-PW){1'b0}}, r_s1.pixel_x});
        py_s = $signed({{(CW-PW){1'b0}}, r_s1.pixel_y});

        in_win  = rect.active && (px_s < rect.win_w) && (py_s < rect.win_h);
        in_rect = !rect.empty &&
                  (px_s >= rect.x_lo) && (px_s < rect.x_hi) &&
                  (py_s >= rect.y_lo) && (py_s < rect.y_hi);
        clearing = !r_cfg.clear_value[carm_pkg::CLEAR_OFF_BIT];

        // Copy uses the source alpha, clear uses the clear value.
        alpha_sel = in_rect ? r_s1.source_alpha
                            : r_cfg.clear_value[carm_pkg::BYTE_W-1:0];
        scaled    = carm_pkg::scale_pixel(r_s1.dest_pixel, alpha_sel);

        n_out.result_pixel = r_s1.dest_pixel;
        n_out.changed      = 1'b0;
        if (in_win && (in_rect || clearing)) begin
            n_out.changed = 1'b1;
            if (r_cfg.additive_mode) begin
                n_out.result_pixel = scaled;
            end else if (in_rect) begin
                n_out.result_pixel = {scaled[31:24], r_s1.dest_pixel[23:0]};
            end else begin
                n_out.result_pixel = {r_cfg.clear_value[carm_pkg::BYTE_W-1:0],
                                      r_s1.dest_pixel[23:0]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= i_in.valid;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pixel_x      <= i_in.pixel_x;
            r_s1.pixel_y      <= i_in.pixel_y;
            r_s1.dest_pixel   <= i_in.dest_pixel;
            r_s1.source_alpha <= i_in.source_alpha;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.result_pixel = r_out.result_pixel;
    assign o_out.changed      = r_out.changed;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both stages are full and stalled");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_v)
        else $error("accepted item lost from the input register");

    a_untouched_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && !n_out.changed) |-> (n_out.result_pixel == r_s1.dest_pixel))
        else $error("untouched pixel does not repeat the destination pixel");

    a_zero_size_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && $stable(r_cfg.copy_size) &&
         ((r_cfg.copy_size[15:0] == '0) || (r_cfg.copy_size[31:16] == '0)))
        |-> !n_out.changed)
        else $error("pixel written with a zero copy size");

    a_stage_moves_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !r_out_v) |=> r_out_v)
        else $error("result register did not take a waiting item");

endmodule
